/* rtl/jaro_similarity_engine_defines.svh */
// Assertion macros shared by the Jaro similarity engine RTL
`ifndef JARO_SIMILARITY_ENGINE_DEFINES_SVH
`define JARO_SIMILARITY_ENGINE_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle
`define JSE_ASSERT_IMPLY(lbl, clk, rst_n, cond, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) else $error(msg);

// Check that a condition implies a consequence in the next cycle
`define JSE_ASSERT_NEXT(lbl, clk, rst_n, cond, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) else $error(msg);

`endif

/* rtl/jse_pkg.sv */
// ----------------------------------------------------------------------------
// jse_pkg
// Types and constants shared by the Jaro similarity engine modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package jse_pkg;

	localparam int FUNC_W    = 2;
	localparam int CHAR_W    = 8;
	localparam int OUT_CNT_W = 7;

	localparam logic [FUNC_W-1:0] FUNC_LOAD_A  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_LOAD_B  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_COMPARE = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EQ_RD,
		ST_EQ_CMP,
		ST_M_A,
		ST_M_B,
		ST_M_C,
		ST_T_A,
		ST_T_C,
		ST_P1,
		ST_P2,
		ST_P3,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

`default_nettype wire

/* rtl/jaro_similarity_engine.sv */
// Jaro similarity engine. Items with func 0 and 1 append char_code to the
// first or second string (up to MAX_LEN each, extra characters are dropped and
// reported in too_long). A func 2 item compares the strings and emits one
// result: similarity in unsigned Q1.FRAC_BITS rounded to nearest, the match
// count and the raw transposition count. The compare runs on the two string
// memories, one read each per cycle: the equality check, the match window walk
// over the first-string characters, the transposition walk over the marks,
// then the products and the serial divider. in_stall stays high meanwhile;
// both strings and marks are cleared when the result is registered.
// ----------------------------------------------------------------------------
// jaro_similarity_engine
// Top level: control sequencer, match marks and fraction arithmetic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "jaro_similarity_engine_defines.svh"

module jaro_similarity_engine import jse_pkg::*; #(
	parameter int MAX_LEN   = 64,
	parameter int FRAC_BITS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [FUNC_W-1:0]    func,
	input  wire logic [CHAR_W-1:0]    char_code,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic      [FRAC_BITS:0]   similarity,
	output logic      [OUT_CNT_W-1:0] match_count,
	output logic      [OUT_CNT_W-1:0] transpositions,
	output logic                      too_long
);

	localparam int CW    = $clog2(MAX_LEN + 1);
	localparam int IDX_W = $clog2(MAX_LEN);
	localparam int NW    = 3 * CW + 4;
	localparam int QW    = FRAC_BITS + 2;

	state_t state_q, state_d;

	logic [CW-1:0]      len1_q, len2_q, i_q, j_q, hi_q, pt_q, m_q, t_q;
	logic               eq_q, ov_q, out_valid_q;
	logic [MAX_LEN-1:0] am_q, bm_q;

	logic [2*CW-1:0] mm_q, ll_q;
	logic [CW:0]     ls_q;
	logic [NW-1:0]   num_a_q, num_b_q, den_a_q;
	logic [FRAC_BITS:0] sim_q;

	logic              in_acc, out_free, hit;
	logic              a_re, b_re, div_start;
	logic [IDX_W-1:0]  a_raddr, b_raddr, i_ix, j_ix, pt_ix;
	logic [CHAR_W-1:0] a_rdata, b_rdata;
	logic              a_we, b_we;
	div_status_t       div_st;
	logic [QW-1:0]     quot;
	logic [QW:0]       q_rnd;
	logic [NW-1:0]     div_num, div_den;
	logic [CW:0]       two_m_t;

	logic [CW-1:0]   lmax, lo_c, hi_c;
	logic signed [CW+1:0] win_s, lo_s, hi_s, i_s;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	assign i_ix  = i_q[IDX_W-1:0];
	assign j_ix  = j_q[IDX_W-1:0];
	assign pt_ix = pt_q[IDX_W-1:0];

	// Match window bounds for the current first-string position
	assign lmax  = (len1_q > len2_q) ? len1_q : len2_q;
	assign win_s = $signed({2'b00, lmax >> 1}) - $signed((CW + 2)'(1));
	assign i_s   = $signed({2'b00, i_q});
	assign lo_s  = i_s - win_s;
	assign hi_s  = i_s + win_s + $signed((CW + 2)'(1));
	assign lo_c  = lo_s[CW+1] ? '0 : lo_s[CW-1:0];
	assign hi_c  = (hi_s > $signed({2'b00, len2_q})) ? len2_q : hi_s[CW-1:0];

	assign hit = !bm_q[j_ix] && (a_rdata == b_rdata);

	// Load writes
	assign a_we = in_acc && (func == FUNC_LOAD_A) && (len1_q < CW'(MAX_LEN));
	assign b_we = in_acc && (func == FUNC_LOAD_B) && (len2_q < CW'(MAX_LEN));

	jse_text_mem #(.DEPTH(MAX_LEN), .AW(IDX_W)) u_mem_a (
		.clk   (clk),
		.we    (a_we),
		.waddr (len1_q[IDX_W-1:0]),
		.wdata (char_code),
		.re    (a_re),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	jse_text_mem #(.DEPTH(MAX_LEN), .AW(IDX_W)) u_mem_b (
		.clk   (clk),
		.we    (b_we),
		.waddr (len2_q[IDX_W-1:0]),
		.wdata (char_code),
		.re    (b_re),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	// Fraction operands
	assign div_num = num_a_q + num_b_q;
	assign div_den = (den_a_q << 2) + (den_a_q << 1);

	jse_divider #(.NW(NW), .QW(QW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.status (div_st),
		.quot   (quot)
	);

	assign q_rnd   = {1'b0, quot} + (QW + 1)'(1);
	assign two_m_t = {m_q, 1'b0} - {1'b0, t_q};

	// Next state and memory read control
	always_comb begin
		state_d   = state_q;
		a_re      = 1'b0;
		b_re      = 1'b0;
		a_raddr   = i_ix;
		b_raddr   = i_ix;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && func == FUNC_COMPARE) begin
					state_d = (len1_q == len2_q && len1_q != '0) ? ST_EQ_RD : ST_M_A;
				end
			end
			ST_EQ_RD: begin
				a_re    = 1'b1;
				b_re    = 1'b1;
				state_d = ST_EQ_CMP;
			end
			ST_EQ_CMP: begin
				if (a_rdata != b_rdata || (i_q + CW'(1)) == len1_q) begin
					state_d = ST_M_A;
				end else begin
					state_d = ST_EQ_RD;
				end
			end
			ST_M_A: begin
				if (i_q == len1_q) begin
					state_d = ST_T_A;
				end else begin
					a_re    = 1'b1;
					state_d = ST_M_B;
				end
			end
			ST_M_B: begin
				if (j_q >= hi_q) begin
					state_d = ST_M_A;
				end else begin
					b_re    = 1'b1;
					b_raddr = j_ix;
					state_d = ST_M_C;
				end
			end
			ST_M_C: begin
				state_d = hit ? ST_M_A : ST_M_B;
			end
			ST_T_A: begin
				if (i_q == len1_q || (am_q[i_ix] && pt_q >= len2_q)) begin
					state_d = (eq_q || m_q == '0) ? ST_FIN : ST_P1;
				end else if (am_q[i_ix] && bm_q[pt_ix]) begin
					a_re    = 1'b1;
					b_re    = 1'b1;
					b_raddr = pt_ix;
					state_d = ST_T_C;
				end
			end
			ST_T_C: state_d = ST_T_A;
			ST_P1:  state_d = ST_P2;
			ST_P2:  state_d = ST_P3;
			ST_P3: begin
				div_start = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				if (div_st.done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Lengths, walk counters and match marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len1_q <= '0;
			len2_q <= '0;
			i_q    <= '0;
			j_q    <= '0;
			hi_q   <= '0;
			pt_q   <= '0;
			m_q    <= '0;
			t_q    <= '0;
			eq_q   <= 1'b0;
			ov_q   <= 1'b0;
			am_q   <= '0;
			bm_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (func)
							FUNC_LOAD_A: begin
								if (a_we) len1_q <= len1_q + CW'(1);
								else      ov_q   <= 1'b1;
							end
							FUNC_LOAD_B: begin
								if (b_we) len2_q <= len2_q + CW'(1);
								else      ov_q   <= 1'b1;
							end
							FUNC_COMPARE: begin
								eq_q <= (len1_q == len2_q);
								i_q  <= '0;
								m_q  <= '0;
								t_q  <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_EQ_CMP: begin
					if (a_rdata != b_rdata) begin
						eq_q <= 1'b0;
						i_q  <= '0;
					end else if ((i_q + CW'(1)) == len1_q) begin
						i_q <= '0;
					end else begin
						i_q <= i_q + CW'(1);
					end
				end
				ST_M_A: begin
					if (i_q == len1_q) begin
						i_q  <= '0;
						pt_q <= '0;
					end else begin
						j_q  <= lo_c;
						hi_q <= hi_c;
					end
				end
				ST_M_B: begin
					if (j_q >= hi_q) i_q <= i_q + CW'(1);
				end
				ST_M_C: begin
					if (hit) begin
						am_q[i_ix] <= 1'b1;
						bm_q[j_ix] <= 1'b1;
						m_q <= m_q + CW'(1);
						i_q <= i_q + CW'(1);
					end else begin
						j_q <= j_q + CW'(1);
					end
				end
				ST_T_A: begin
					if (i_q == len1_q || (am_q[i_ix] && pt_q >= len2_q)) begin
						i_q <= i_q;
					end else if (!am_q[i_ix]) begin
						i_q <= i_q + CW'(1);
					end else if (!bm_q[pt_ix]) begin
						pt_q <= pt_q + CW'(1);
					end
				end
				ST_T_C: begin
					if (a_rdata != b_rdata) t_q <= t_q + CW'(1);
					i_q  <= i_q + CW'(1);
					pt_q <= pt_q + CW'(1);
				end
				ST_FIN: begin
					if (out_free) begin
						len1_q <= '0;
						len2_q <= '0;
						ov_q   <= 1'b0;
						am_q   <= '0;
						bm_q   <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// Products, similarity value and result fields
	always_ff @(posedge clk) begin
		case (state_q)
			ST_T_A: begin
				sim_q <= eq_q ? (FRAC_BITS + 1)'(1) << FRAC_BITS : '0;
			end
			ST_P1: begin
				mm_q <= (2 * CW)'(m_q) * (2 * CW)'(m_q);
				ll_q <= (2 * CW)'(len1_q) * (2 * CW)'(len2_q);
				ls_q <= {1'b0, len1_q} + {1'b0, len2_q};
			end
			ST_P2: begin
				num_a_q <= (NW'(mm_q) * NW'(ls_q)) << 1;
				den_a_q <= NW'(ll_q) * NW'(m_q);
				num_b_q <= NW'(ll_q) * NW'(two_m_t);
			end
			ST_DIV: begin
				if (div_st.done) sim_q <= q_rnd[FRAC_BITS+1:1];
			end
			ST_FIN: begin
				if (out_free) begin
					similarity     <= sim_q;
					match_count    <= OUT_CNT_W'(m_q);
					transpositions <= OUT_CNT_W'(t_q);
					too_long       <= ov_q;
				end
			end
			default: ;
		endcase
	end

	// Result valid: drop on transaction, raise when a compare finishes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	`JSE_ASSERT_IMPLY(a_sim_range, clk, arst_n, out_valid, similarity <= ((FRAC_BITS + 1)'(1) << FRAC_BITS), "similarity above one")
	`JSE_ASSERT_IMPLY(a_trans_le_match, clk, arst_n, state_q == ST_FIN, t_q <= m_q && m_q <= len1_q && m_q <= len2_q, "transposition or match count out of range")
	`JSE_ASSERT_NEXT(a_fin_clears, clk, arst_n, state_q == ST_FIN && out_free, len1_q == '0 && len2_q == '0 && am_q == '0 && bm_q == '0 && out_valid, "strings not cleared after compare")
	`JSE_ASSERT_IMPLY(a_div_only_in_div, clk, arst_n, div_st.busy, state_q == ST_DIV, "divider busy outside divide phase")

endmodule

`default_nettype wire

/* rtl/jse_text_mem.sv */
// ----------------------------------------------------------------------------
// jse_text_mem
// Single write port, single read port string store with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jse_text_mem import jse_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [AW-1:0]     waddr,
	input  wire logic [CHAR_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [AW-1:0]     raddr,
	output logic      [CHAR_W-1:0] rdata
);

	logic [CHAR_W-1:0] mem [DEPTH];

	// Write one character
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read, hold data between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/jse_divider.sv */
// ----------------------------------------------------------------------------
// jse_divider
// Restoring divider, one quotient bit per cycle, for num <= den fractions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jse_divider import jse_pkg::*; #(
	parameter int NW = 25,
	parameter int QW = 18
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] num,
	input  wire logic [NW-1:0] den,
	output div_status_t        status,
	output logic      [QW-1:0] quot
);

	localparam int CNTW = $clog2(QW + 1);

	logic [NW:0]     rem_q;
	logic [NW-1:0]   den_q;
	logic [CNTW-1:0] cnt_q;
	logic            done_q;
	logic            ge;
	logic [NW:0]     diff;

	assign ge   = rem_q >= {1'b0, den_q};
	assign diff = ge ? (rem_q - {1'b0, den_q}) : rem_q;

	// Step count and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNTW'(QW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNTW'(1);
				done_q <= (cnt_q == CNTW'(1));
			end
		end
	end

	// Shift in one quotient bit per step
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num};
			den_q <= den;
			quot  <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= {diff[NW-1:0], 1'b0};
			quot  <= {quot[QW-2:0], ge};
		end
	end

	assign status.busy = (cnt_q != '0);
	assign status.done = done_q;

endmodule

`default_nettype wire

/* tb/jaro_similarity_engine_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Jaro similarity engine testbench
// Loads string pairs through the input channel, issues compares and checks
// every result against a built-in predictor of the matching walk, the
// transposition count and the rounded Q1.16 fraction. Both channels idle at
// random, with one long stretch where neither side idles.
// ----------------------------------------------------------------------------
module jaro_similarity_engine_test;
	import jse_pkg::*;

	localparam int MAX_LEN   = 64;
	localparam int FRAC_BITS = 16;
	localparam int N_ITEMS   = 900;
	localparam int CYCLE_LIMIT = 2000000;
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	typedef struct packed {
		logic [FRAC_BITS:0]   sim;
		logic [OUT_CNT_W-1:0] m;
		logic [OUT_CNT_W-1:0] t;
		logic                 ovf;
	} score_t;

	typedef struct packed {
		logic [FUNC_W-1:0] f;
		logic [CHAR_W-1:0] c;
		logic              typed;
		score_t            want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [FUNC_W-1:0] func = '0;
	logic [CHAR_W-1:0] char_code = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [FRAC_BITS:0] similarity;
	logic [OUT_CNT_W-1:0] match_count;
	logic [OUT_CNT_W-1:0] transpositions;
	logic too_long;

	jaro_similarity_engine #(.MAX_LEN(MAX_LEN), .FRAC_BITS(FRAC_BITS)) DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .char_code(char_code),
		.out_valid(out_valid), .out_stall(out_stall),
		.similarity(similarity), .match_count(match_count),
		.transpositions(transpositions), .too_long(too_long)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [CHAR_W-1:0] str_a [MAX_LEN];
	logic [CHAR_W-1:0] str_b [MAX_LEN];
	int len_a, len_b;
	bit dropped;
	score_t pending_scores[$];
	bit typed_q[$];
	score_t typed_vals[$];
	bit failed = 1'b0;
	bit calm = 1'b0;
	int cycles = 0;
	int sent = 0;

	// Rounded ratio num/den in Q1.FRAC_BITS, ties up
	function automatic longint unsigned round_ratio(longint unsigned num,
			longint unsigned den);
		longint unsigned scaled;
		scaled = (num << (FRAC_BITS + 1)) / den;
		return (scaled + 1) >> 1;
	endfunction

	// Score the loaded strings, then clear them
	function automatic score_t score_strings();
		score_t s;
		bit ma [MAX_LEN];
		bit mb [MAX_LEN];
		int win, lo, hi, p;
		longint unsigned m, t, l1, l2, num, den;
		bit same;
		m = 0; t = 0; p = 0;
		foreach (ma[k]) begin
			ma[k] = 0;
			mb[k] = 0;
		end
		win = ((len_a > len_b) ? len_a : len_b) / 2 - 1;
		for (int i = 0; i < len_a; i++) begin
			lo = (i - win < 0) ? 0 : i - win;
			hi = (i + win + 1 > len_b) ? len_b : i + win + 1;
			for (int j = lo; j < hi; j++) begin
				if (!mb[j] && str_a[i] == str_b[j]) begin
					ma[i] = 1;
					mb[j] = 1;
					m++;
					break;
				end
			end
		end
		for (int i = 0; i < len_a; i++) begin
			if (ma[i]) begin
				while (p < len_b && !mb[p])
					p++;
				if (p >= len_b)
					break;
				if (str_a[i] != str_b[p])
					t++;
				p++;
			end
		end
		same = (len_a == len_b);
		for (int k = 0; k < len_a && same; k++)
			if (str_a[k] != str_b[k])
				same = 0;
		if (same)
			s.sim = (FRAC_BITS + 1)'(1) << FRAC_BITS;
		else if (m == 0)
			s.sim = '0;
		else begin
			l1 = len_a;
			l2 = len_b;
			num = 2*m*m*l2 + 2*m*m*l1 + l1*l2*(2*m - t);
			den = 6*l1*l2*m;
			s.sim = (FRAC_BITS + 1)'(round_ratio(num, den));
		end
		s.m = OUT_CNT_W'(m);
		s.t = OUT_CNT_W'(t);
		s.ovf = dropped;
		len_a = 0;
		len_b = 0;
		dropped = 0;
		return s;
	endfunction

	// Advance the predictor by one accepted transaction
	task automatic predict_item(input logic [FUNC_W-1:0] f, input logic [CHAR_W-1:0] c);
		case (f)
			FUNC_LOAD_A: begin
				if (len_a < MAX_LEN) str_a[len_a++] = c;
				else dropped = 1;
			end
			FUNC_LOAD_B: begin
				if (len_b < MAX_LEN) str_b[len_b++] = c;
				else dropped = 1;
			end
			FUNC_COMPARE: pending_scores.insert(pending_scores.size(), score_strings());
			default: ;
		endcase
	endtask

	// Drive one transaction and hold it until accepted
	task automatic send_item(input logic [FUNC_W-1:0] f, input logic [CHAR_W-1:0] c);
		while (!calm && $urandom_range(99) < 12) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		char_code <= c;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_item(f, c);
		sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input int which, input int n, input int alpha);
		for (int k = 0; k < n; k++)
			send_item(which ? FUNC_LOAD_B : FUNC_LOAD_A,
				CHAR_W'($urandom_range(alpha - 1) + 8'h61));
	endtask

	// Check each result transaction against the oldest expectation
	always @(posedge clk) begin
		score_t want;
		score_t typed_want;
		bit is_typed;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_scores.size() == 0) begin
				$error("unexpected result transaction");
				failed = 1'b1;
			end else begin
				want = pending_scores.pop_front();
				if (typed_q.size() > 0) begin
					is_typed = typed_q.pop_front();
					typed_want = typed_vals.pop_front();
					if (is_typed && typed_want != want) begin
						$error("typed expectation disagrees with predictor");
						failed = 1'b1;
					end
				end
				if (similarity !== want.sim) begin
					$error("similarity: expected %0d, actual %0d", want.sim, similarity);
					failed = 1'b1;
				end
				if (match_count !== want.m) begin
					$error("match_count: expected %0d, actual %0d", want.m, match_count);
					failed = 1'b1;
				end
				if (transpositions !== want.t) begin
					$error("transpositions: expected %0d, actual %0d", want.t, transpositions);
					failed = 1'b1;
				end
				if (too_long !== want.ovf) begin
					$error("too_long: expected %0d, actual %0d", want.ovf, too_long);
					failed = 1'b1;
				end
			end
		end
	end

	// Stall the result channel at random
	always @(negedge clk)
		out_stall <= !calm && ($urandom_range(99) < 12);

	// Stop a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Directed rows; typed marks a compare whose result is known by inspection
	row_t plan [] = '{
		'{FUNC_COMPARE, 8'h00, 1'b1, '{17'h10000, 7'd0, 7'd0, 1'b0}},
		'{FUNC_LOAD_A,  8'hFF, 1'b0, '0},
		'{FUNC_LOAD_B,  8'hFF, 1'b0, '0},
		'{FUNC_COMPARE, 8'hFF, 1'b1, '{17'h10000, 7'd0, 7'd0, 1'b0}},
		'{FUNC_LOAD_A,  8'h00, 1'b0, '0},
		'{FUNC_LOAD_B,  8'h01, 1'b0, '0},
		'{FUNC_COMPARE, 8'h00, 1'b1, '{17'h00000, 7'd0, 7'd0, 1'b0}},
		'{FUNC_UNUSED,  8'hAA, 1'b0, '0},
		'{FUNC_LOAD_A,  8'h61, 1'b0, '0},
		'{FUNC_LOAD_A,  8'h62, 1'b0, '0},
		'{FUNC_LOAD_A,  8'h63, 1'b0, '0},
		'{FUNC_LOAD_A,  8'h64, 1'b0, '0},
		'{FUNC_LOAD_B,  8'h62, 1'b0, '0},
		'{FUNC_LOAD_B,  8'h61, 1'b0, '0},
		'{FUNC_LOAD_B,  8'h64, 1'b0, '0},
		'{FUNC_LOAD_B,  8'h63, 1'b0, '0},
		'{FUNC_COMPARE, 8'h55, 1'b0, '0},
		'{FUNC_LOAD_A,  8'h61, 1'b0, '0},
		'{FUNC_COMPARE, 8'h00, 1'b0, '0}
	};

	initial begin
		int alpha;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		len_a = 0;
		len_b = 0;
		dropped = 0;

		// directed part
		foreach (plan[r]) begin
			if (plan[r].f == FUNC_COMPARE) begin
				typed_q.insert(typed_q.size(), plan[r].typed);
				typed_vals.insert(typed_vals.size(), plan[r].want);
			end
			send_item(plan[r].f, plan[r].c);
		end
		// full strings with overflow on each side
		for (int s = 0; s < 2; s++) begin
			send_text(0, MAX_LEN + s, 2);
			send_text(1, MAX_LEN + 1 - s, 2);
			typed_q.insert(typed_q.size(), 1'b0);
			typed_vals.insert(typed_vals.size(), '0);
			send_item(FUNC_COMPARE, 8'h00);
		end

		// random part: mostly well-formed pairs of short strings
		while (sent < N_ITEMS) begin
			if (sent > N_ITEMS / 3 && sent < N_ITEMS / 2) calm = 1'b1;
			else calm = 1'b0;
			case ($urandom_range(9))
				0: begin
					send_item(FUNC_W'($urandom_range(3)), CHAR_W'($urandom));
				end
				1: begin
					send_item(FUNC_LOAD_A, CHAR_W'($urandom));
					send_item(FUNC_LOAD_B, CHAR_W'($urandom));
					send_item(FUNC_COMPARE, CHAR_W'($urandom));
				end
				default: begin
					alpha = $urandom_range(1, 6);
					send_text(0, $urandom_range(0, 12), alpha);
					send_text(1, $urandom_range(0, 12), alpha);
					if ($urandom_range(9) == 0)
						send_text($urandom_range(1), $urandom_range(20, 60), alpha);
					send_item(FUNC_COMPARE, CHAR_W'($urandom));
				end
			endcase
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		while (pending_scores.size() != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
		if (!failed)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

/* files.f */
+incdir+rtl
rtl/jse_pkg.sv
rtl/jse_text_mem.sv
rtl/jse_divider.sv
rtl/jaro_similarity_engine.sv
tb/jaro_similarity_engine_test.sv
